// File: rtl/gond_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gond_pkg
// Shared types, field widths and register codes of the open-neighbour degree
// stencil.
// ----------------------------------------------------------------------------
package gond_pkg;

  localparam int GRID_W_BITS = 9;
  localparam int GRID_H_BITS = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int DEG_W       = 3;
  localparam int COL_W       = 8;
  localparam int ROW_W       = 12;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  localparam logic REQ_CELL  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // slot codes of the three-row ring
  localparam logic [1:0] SLOT_0 = 2'd0;
  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;

  // one accepted transaction on its way from the memory read to the result
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             south_ok;
    logic             south_blk;
    logic             north_ok;
    logic             west_ok;
    logic             east_ok;
    logic             last;
    logic [1:0]       mid_slot;
    logic [1:0]       north_slot;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } stg_t;

  function automatic logic pick(input logic [2:0] word, input logic [1:0] slot);
    logic b;
    case (slot)
      SLOT_0:  b = word[0];
      SLOT_1:  b = word[1];
      SLOT_2:  b = word[2];
      default: b = word[0];
    endcase
    return b;
  endfunction

endpackage

// File: rtl/gond_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gond_if
// Valid/ready channels of the stencil: cell input, result output, register
// write port.
// ----------------------------------------------------------------------------
interface gond_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic blocked;

  modport source (output valid, output req_type, output blocked, input ready);
  modport sink   (input valid, input req_type, input blocked, output ready);
endinterface

interface gond_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] degree;
  logic [7:0] cell_col;
  logic [11:0] cell_row;
  logic       cell_blocked;
  logic       last_cell;

  modport source (output valid, output degree, output cell_col, output cell_row,
                  output cell_blocked, output last_cell, input ready);
  modport sink   (input valid, input degree, input cell_col, input cell_row,
                  input cell_blocked, input last_cell, output ready);
endinterface

interface gond_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [12:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/gond_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gond_mem
// Column-organized row ring: one 3-bit word per column, one bit per ring
// slot. Bit-write port, two registered read ports.
// ----------------------------------------------------------------------------
module gond_mem #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [1:0]               wslot,
  input  logic                     wbit,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [2:0]               rdata_a,
  output logic [2:0]               rdata_b
);
  import gond_pkg::*;

  logic [2:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      case (wslot)
        SLOT_0:  mem[waddr][0] <= wbit;
        SLOT_1:  mem[waddr][1] <= wbit;
        SLOT_2:  mem[waddr][2] <= wbit;
        default: mem[waddr][0] <= wbit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/gond_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gond_ctrl
// Grid registers, raster and flush counters, memory addressing and the
// stage register that travels alongside the memory read.
// ----------------------------------------------------------------------------
module gond_ctrl #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic                          in_blocked,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gond_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gond_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          adv,
  output gond_pkg::stg_t                stg,
  output logic                          mem_we,
  output logic [$clog2(MAX_WIDTH)-1:0]  mem_waddr,
  output logic [1:0]                    mem_wslot,
  output logic                          mem_wbit,
  output logic                          mem_re,
  output logic [$clog2(MAX_WIDTH)-1:0]  mem_raddr_a,
  output logic [$clog2(MAX_WIDTH)-1:0]  mem_raddr_b
);
  import gond_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RST_W = (8 > MAX_WIDTH) ? MAX_WIDTH : 8;
  localparam int RST_H = (8 > MAX_HEIGHT) ? MAX_HEIGHT : 8;

  logic [WW-1:0] wid_r, wid_nxt;
  logic [HW-1:0] hgt_r, hgt_nxt;
  logic [AW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic [1:0]    slot_r, slot_nxt;
  stg_t          stg_r, stg_nxt;

  logic [GRID_W_BITS-1:0] cfg_w;
  logic [GRID_H_BITS-1:0] cfg_h;
  logic          cfg_fire;
  logic          acc;
  logic          raster;
  logic          full;
  logic          fire;
  logic          col_last;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_w     = cfg_data[GRID_W_BITS-1:0];
  assign cfg_h     = cfg_data[GRID_H_BITS-1:0];

  assign in_ready = !stg_r.valid || adv;
  assign acc      = in_valid && in_ready;
  assign raster   = (in_req_type == REQ_CELL);
  assign full     = (row_r == hgt_r);
  assign fire     = acc && (raster ? !full : full);
  assign col_last = ((WW'(col_r) + WW'(1)) == wid_r);

  assign mem_we      = fire && raster;
  assign mem_waddr   = col_r;
  assign mem_wslot   = slot_r;
  assign mem_wbit    = in_blocked;
  assign mem_re      = fire;
  assign mem_raddr_a = col_r;
  assign mem_raddr_b = col_r + AW'(1);

  assign stg = stg_r;

  always_comb begin
    wid_nxt  = wid_r;
    hgt_nxt  = hgt_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    stg_nxt  = stg_r;

    if (adv) begin
      stg_nxt.valid = 1'b0;
    end

    if (fire) begin
      stg_nxt.valid      = 1'b1;
      stg_nxt.emit       = raster ? (row_r != '0) : 1'b1;
      stg_nxt.south_ok   = raster;
      stg_nxt.south_blk  = in_blocked;
      stg_nxt.north_ok   = (row_r >= HW'(2));
      stg_nxt.west_ok    = (col_r != '0);
      stg_nxt.east_ok    = !col_last;
      stg_nxt.last       = !raster && col_last;
      stg_nxt.mid_slot   = (slot_r == SLOT_0) ? SLOT_2 : slot_r - 2'd1;
      stg_nxt.north_slot = (slot_r == SLOT_2) ? SLOT_0 : slot_r + 2'd1;
      stg_nxt.col        = COL_W'(col_r);
      stg_nxt.row        = ROW_W'(row_r - HW'(1));

      if (!col_last) begin
        col_nxt = col_r + AW'(1);
      end else if (raster) begin
        col_nxt  = '0;
        row_nxt  = row_r + HW'(1);
        slot_nxt = (slot_r == SLOT_2) ? SLOT_0 : slot_r + 2'd1;
      end else begin
        col_nxt  = '0;
        row_nxt  = '0;
        slot_nxt = SLOT_0;
      end
    end

    if (cfg_fire) begin
      case (cfg_index)
        REG_GRID_WIDTH: begin
          if (cfg_w == '0) wid_nxt = WW'(1);
          else if (32'(cfg_w) > 32'(MAX_WIDTH)) wid_nxt = WW'(MAX_WIDTH);
          else wid_nxt = WW'(cfg_w);
        end
        REG_GRID_HEIGHT: begin
          if (cfg_h == '0) hgt_nxt = HW'(1);
          else if (32'(cfg_h) > 32'(MAX_HEIGHT)) hgt_nxt = HW'(MAX_HEIGHT);
          else hgt_nxt = HW'(cfg_h);
        end
        default: begin
        end
      endcase
      col_nxt  = '0;
      row_nxt  = '0;
      slot_nxt = SLOT_0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_r  <= WW'(RST_W);
      hgt_r  <= HW'(RST_H);
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= SLOT_0;
      stg_r  <= '0;
    end else begin
      wid_r  <= wid_nxt;
      hgt_r  <= hgt_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
      stg_r  <= stg_nxt;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < wid_r)
    else $error("column counter past grid width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= hgt_r)
    else $error("row counter past grid height");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> (col_r == '0) && (row_r == '0) && (slot_r == SLOT_0))
    else $error("register write did not restart the grid");

endmodule

// File: rtl/gond_stencil.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gond_stencil
// Neighbour count from the two column words read from the ring, the west
// column kept from the previous transaction, and the result register.
// ----------------------------------------------------------------------------
module gond_stencil (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gond_pkg::stg_t                  stg,
  input  logic [2:0]                      rd_c,
  input  logic [2:0]                      rd_e,
  output logic                            adv,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gond_pkg::DEG_W-1:0]      out_degree,
  output logic [gond_pkg::COL_W-1:0]      out_cell_col,
  output logic [gond_pkg::ROW_W-1:0]      out_cell_row,
  output logic                            out_cell_blocked,
  output logic                            out_last_cell
);
  import gond_pkg::*;

  logic             west_r;
  logic             out_valid_r, out_valid_nxt;
  logic [DEG_W-1:0] degree_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             blk_r;
  logic             last_r;

  logic             self_blk;
  logic             n_open, s_open, w_open, e_open;
  logic [DEG_W-1:0] deg;
  logic             out_free;
  logic             load;

  assign self_blk = pick(rd_c, stg.mid_slot);
  assign n_open   = stg.north_ok && !pick(rd_c, stg.north_slot);
  assign s_open   = stg.south_ok && !stg.south_blk;
  assign w_open   = stg.west_ok && !west_r;
  assign e_open   = stg.east_ok && !pick(rd_e, stg.mid_slot);
  assign deg      = self_blk ? '0 :
                    DEG_W'(n_open) + DEG_W'(s_open) + DEG_W'(w_open) + DEG_W'(e_open);

  assign out_free = !out_valid_r || out_ready;
  assign adv      = stg.valid && (!stg.emit || out_free);
  assign load     = adv && stg.emit;

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      west_r <= self_blk;
    end
    if (load) begin
      degree_r <= deg;
      col_r    <= stg.col;
      row_r    <= stg.row;
      blk_r    <= self_blk;
      last_r   <= stg.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_degree       = degree_r;
  assign out_cell_col     = col_r;
  assign out_cell_row     = row_r;
  assign out_cell_blocked = blk_r;
  assign out_last_cell    = last_r;

  a_blocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && blk_r |-> degree_r == '0)
    else $error("blocked cell with nonzero degree");

  a_degree_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> degree_r <= DEG_W'(4))
    else $error("degree above four");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(col_r) && $stable(row_r))
    else $error("pending result overwritten");

endmodule

// File: rtl/grid_open_neighbour_degree.sv
`timescale 1ns / 1ps
// Path: an accepted releasing transaction passes the memory read stage, then the result register
//   that raises out_ch.valid; a result the receiver has not yet taken stalls it between the two.
// Throughput: one transaction per cycle unless the output stalls, cells and flush ticks alike; set by the single
//   read-modify-write pass through the column ring memory (two read ports, one bit-write).
// Reset: rst_n clears counters, valids and grid size to 8 by 8; ring memory is not cleared,
//   every cell is written in a grid before it is read.
// ----------------------------------------------------------------------------
// grid_open_neighbour_degree
// Streaming open 4-neighbour degree of a raster grid, three-row ring in memory.
// ----------------------------------------------------------------------------
module grid_open_neighbour_degree #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  gond_in_if.sink           in_ch,
  gond_out_if.source        out_ch,
  gond_cfg_if.sink          cfg_ch
);
  import gond_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  stg_t          stg;
  logic          adv;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [1:0]    mem_wslot;
  logic          mem_wbit;
  logic          mem_re;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  logic [2:0]    rd_c;
  logic [2:0]    rd_e;

  gond_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .in_blocked  (in_ch.blocked),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .adv         (adv),
    .stg         (stg),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wslot   (mem_wslot),
    .mem_wbit    (mem_wbit),
    .mem_re      (mem_re),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b)
  );

  gond_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wslot   (mem_wslot),
    .wbit    (mem_wbit),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (rd_c),
    .rdata_b (rd_e)
  );

  gond_stencil u_stencil (
    .clk              (clk),
    .rst_n            (rst_n),
    .stg              (stg),
    .rd_c             (rd_c),
    .rd_e             (rd_e),
    .adv              (adv),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_degree       (out_ch.degree),
    .out_cell_col     (out_ch.cell_col),
    .out_cell_row     (out_ch.cell_row),
    .out_cell_blocked (out_ch.cell_blocked),
    .out_last_cell    (out_ch.last_cell)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the open-neighbour degree stencil. A queue-fed driver
// streams raster cells and flush ticks in bursts. A stalling receiver takes the
// results, and a monitor checks each one against a cycle-free model of the
// three-row ring kept in the bench. The grid size is changed between phases,
// including zero and oversized register values.
// ----------------------------------------------------------------------------
module testbench;
  import gond_pkg::*;

  localparam int GRID_MAX_W    = 256;
  localparam int GRID_MAX_H    = 4096;
  localparam int TOTAL_ITEMS   = 1300;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int FULL_GRID_CAP = 240;

  localparam logic [8:0] CROSS_PATTERN = 9'h105;

  typedef enum int unsigned {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic req;
    logic blk;
  } cell_item_t;

  typedef struct packed {
    logic [DEG_W-1:0] degree;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             blk;
    logic             last;
  } degree_rec_t;

  logic clk = 1'b0;
  logic rst_n;

  gond_in_if  in_ch ();
  gond_out_if out_ch ();
  gond_cfg_if cfg_ch ();

  grid_open_neighbour_degree #(
    .MAX_WIDTH (GRID_MAX_W),
    .MAX_HEIGHT(GRID_MAX_H)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // model state
  bit                     ring_bits [3*GRID_MAX_W];
  logic [GRID_W_BITS-1:0] width_reg;
  logic [GRID_H_BITS-1:0] height_reg;
  int unsigned            next_col, next_row, next_out;

  degree_rec_t degree_q[$];
  cell_item_t  cell_q[$];

  int unsigned cells_taken, cfg_taken, results_seen, grids_done, err_count;
  int unsigned burst_left, gap_left;
  int unsigned hold_req, hold_done, hold_left, rx_cycle;
  int unsigned quiet_cycles;
  int unsigned items_queued;
  rx_mode_t    rx_mode;

  function automatic int unsigned used_width();
    if (width_reg == 0) return 1;
    if (width_reg > GRID_MAX_W) return GRID_MAX_W;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned used_height();
    if (height_reg == 0) return 1;
    if (height_reg > GRID_MAX_H) return GRID_MAX_H;
    return 32'(height_reg);
  endfunction

  function automatic bit ring_at(int unsigned r, int unsigned c);
    return ring_bits[(r % 3) * GRID_MAX_W + (c % GRID_MAX_W)];
  endfunction

  function automatic void restart_grid();
    next_col = 0;
    next_row = 0;
    next_out = 0;
  endfunction

  function automatic degree_rec_t cell_degree(int unsigned r, int unsigned c,
                                              int unsigned w, int unsigned h);
    degree_rec_t rec;
    int unsigned n;
    n = 0;
    rec.blk = ring_at(r, c);
    if (!rec.blk) begin
      if (r > 0 && !ring_at(r - 1, c)) n++;
      if (r + 1 < h && !ring_at(r + 1, c)) n++;
      if (c > 0 && !ring_at(r, c - 1)) n++;
      if (c + 1 < w && !ring_at(r, c + 1)) n++;
    end
    rec.degree = DEG_W'(n);
    rec.col    = COL_W'(c);
    rec.row    = ROW_W'(r);
    rec.last   = (r == h - 1) && (c == w - 1);
    return rec;
  endfunction

  function automatic void predict_item(logic req, logic blk);
    int unsigned w, h, total;
    w = used_width();
    h = used_height();
    total = w * h;
    if (req == REQ_CELL) begin
      if (next_row < h && next_col < w) begin
        ring_bits[(next_row % 3) * GRID_MAX_W + next_col] = blk;
        if (next_row > 0) begin
          degree_q.push_back(cell_degree(next_row - 1, next_col, w, h));
          next_out = (next_row - 1) * w + next_col + 1;
        end
        next_col++;
        if (next_col >= w) begin
          next_col = 0;
          next_row++;
        end
      end
    end else if (next_row >= h && next_out < total) begin
      degree_q.push_back(cell_degree(next_out / w, next_out % w, w, h));
      next_out++;
      if (next_out >= total) restart_grid();
    end
  endfunction

  function automatic void predict_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    if (idx == REG_GRID_WIDTH) width_reg = value[GRID_W_BITS-1:0];
    else if (idx == REG_GRID_HEIGHT) height_reg = value[GRID_H_BITS-1:0];
    restart_grid();
  endfunction

  // driver: bursts of random length, random gaps
  always @(posedge clk) begin
    cell_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      width_reg  = 9'd8;
      height_reg = 13'd8;
      restart_grid();
      burst_left  = 0;
      gap_left    = 0;
      cells_taken = 0;
      cfg_taken   = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        predict_cfg(cfg_ch.index, cfg_ch.data);
        cfg_taken++;
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_item(in_ch.req_type, in_ch.blocked);
        cells_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (cell_q.size() > 0) begin
          it = cell_q.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.req_type <= it.req;
          in_ch.blocked  <= it.blk;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      hold_done = 0;
      rx_cycle  = 0;
      rx_mode   = RX_FREE;
    end else begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_left == 0 && hold_req != hold_done) begin
        hold_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:  out_ch.ready <= 1'b1;
          RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_ch.ready <= ($urandom_range(0, 9) < 4);
          default:  out_ch.ready <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    degree_rec_t want, got;
    if (!rst_n) begin
      results_seen = 0;
      grids_done   = 0;
      err_count    = 0;
    end else if (out_ch.valid && out_ch.ready) begin
      got.degree = out_ch.degree;
      got.col    = out_ch.cell_col;
      got.row    = out_ch.cell_row;
      got.blk    = out_ch.cell_blocked;
      got.last   = out_ch.last_cell;
      results_seen++;
      if (got.last) grids_done++;
      if (degree_q.size() == 0) begin
        if (err_count < 10)
          $display("%0t: unexpected result deg=%0d col=%0d row=%0d blk=%0d last=%0d",
                   $realtime, got.degree, got.col, got.row, got.blk, got.last);
        err_count++;
      end else begin
        want = degree_q.pop_front();
        if (got.degree !== want.degree || got.col !== want.col || got.row !== want.row ||
            got.blk !== want.blk || got.last !== want.last) begin
          if (err_count < 10) begin
            $display("%0t: mismatch exp deg=%0d col=%0d row=%0d blk=%0d last=%0d",
                     $realtime, want.degree, want.col, want.row, want.blk, want.last);
            $display("%0t:          got deg=%0d col=%0d row=%0d blk=%0d last=%0d",
                     $realtime, got.degree, got.col, got.row, got.blk, got.last);
          end
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, degree_q.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic void push_item(logic req, logic blk);
    cell_item_t it;
    it.req = req;
    it.blk = blk;
    cell_q.push_back(it);
    items_queued++;
  endfunction

  function automatic logic pick_blocked(int unsigned dens);
    return ($urandom_range(0, 99) < dens);
  endfunction

  // ncells raster cells then nflush ticks; noisy adds ignored items in between
  function automatic void push_grid(int unsigned ncells, int unsigned nflush,
                                    int unsigned dens, bit noisy);
    for (int unsigned i = 0; i < ncells; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) push_item(REQ_FLUSH, 1'($urandom_range(0, 1)));
      push_item(REQ_CELL, pick_blocked(dens));
    end
    if (noisy) begin
      repeat ($urandom_range(0, 3)) push_item(REQ_CELL, 1'($urandom_range(0, 1)));
    end
    for (int unsigned i = 0; i < nflush; i++) push_item(REQ_FLUSH, 1'($urandom_range(0, 1)));
    if (noisy) push_item(REQ_FLUSH, 1'($urandom_range(0, 1)));
  endfunction

  function automatic int unsigned pick_density();
    case ($urandom_range(0, 6))
      0:       return 0;
      1:       return 20;
      2:       return 80;
      3:       return 100;
      default: return 50;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_width_data();
    logic [GRID_W_BITS-1:0] w9;
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) w9 = '0;
    else if (r == 1) w9 = GRID_W_BITS'($urandom_range(257, 511));
    else if (r == 2) w9 = GRID_W_BITS'(256);
    else if (r < 6) w9 = GRID_W_BITS'($urandom_range(13, 40));
    else w9 = GRID_W_BITS'($urandom_range(1, 12));
    return {4'($urandom_range(0, 15)), w9};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_height_data();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return CFG_DATA_W'($urandom_range(4097, 8191));
    if (r == 2) return CFG_DATA_W'(4096);
    if (r < 6) return CFG_DATA_W'($urandom_range(13, 40));
    return CFG_DATA_W'($urandom_range(1, 12));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // sampled mid-cycle so the driver's updates at the edge are settled
  task automatic drain();
    while (cell_q.size() != 0 || in_ch.valid || degree_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned w, h, total, n, shape;
    bit need_write;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_CELL;
    in_ch.blocked  = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_GRID_WIDTH;
    cfg_ch.data    = '0;
    out_ch.ready   = 1'b0;
    hold_req       = 0;
    items_queued   = 0;
    rst_n          = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset-size grid, no register write yet
    push_grid(64, 8, 30, 1'b0);
    drain();

    // 3x3 with a degree-4 center; early flush, late cell and spare flush are ignored
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(3));
    push_item(REQ_FLUSH, 1'b0);
    for (int i = 0; i < 9; i++) push_item(REQ_CELL, CROSS_PATTERN[i]);
    push_item(REQ_CELL, 1'b0);
    repeat (3) push_item(REQ_FLUSH, 1'b1);
    push_item(REQ_FLUSH, 1'b0);
    drain();

    // zero registers act as a 1x1 grid
    write_reg(REG_GRID_WIDTH, 13'h1E00);
    write_reg(REG_GRID_HEIGHT, 13'h0000);
    push_item(REQ_CELL, 1'b0);
    push_item(REQ_FLUSH, 1'b0);
    push_item(REQ_FLUSH, 1'b1);
    push_item(REQ_CELL, 1'b1);
    push_item(REQ_FLUSH, 1'b0);
    drain();

    // oversized width clamps to full width, two rows; receiver holds off so the block backs up
    write_reg(REG_GRID_WIDTH, 13'h1FFF);
    write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(2));
    push_grid(300, 0, 40, 1'b0);
    while (cell_q.size() > 40) @(posedge clk);
    hold_req++;
    drain();

    // oversized and maximum heights, partial grids
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(1));
    write_reg(REG_GRID_HEIGHT, 13'h1FFF);
    push_grid(200, 0, 50, 1'b0);
    drain();
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(2));
    write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(4096));
    push_grid(100, 0, 50, 1'b0);

    need_write = 1'b1;
    while (items_queued < TOTAL_ITEMS) begin
      shape = $urandom_range(0, 9);
      if (need_write || $urandom_range(0, 2) == 0) begin
        drain();
        case ($urandom_range(0, 2))
          0: write_reg(REG_GRID_WIDTH, random_width_data());
          1: write_reg(REG_GRID_HEIGHT, random_height_data());
          default: begin
            write_reg(REG_GRID_WIDTH, random_width_data());
            write_reg(REG_GRID_HEIGHT, random_height_data());
          end
        endcase
        need_write = 1'b0;
      end
      w = used_width();
      h = used_height();
      total = w * h;
      if (shape == 9) begin
        repeat ($urandom_range(1, 30))
          push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        need_write = 1'b1;
      end else if (shape == 8 || total > FULL_GRID_CAP) begin
        n = $urandom_range(1, (total > FULL_GRID_CAP) ? FULL_GRID_CAP : total);
        push_grid(n, 0, pick_density(), 1'b0);
        need_write = 1'b1;
      end else begin
        push_grid(total, w, pick_density(), shape == 7);
      end
      if ($urandom_range(0, 9) == 0) hold_req++;
    end
    drain();

    $display("covered %0d input transactions, %0d results, %0d register writes",
             cells_taken, results_seen, cfg_taken);
    $display("%0d grids completed; sizes from 1x1 up to full width and height were driven",
             grids_done);
    if (err_count == 0 && degree_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", err_count, degree_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/gond_pkg.sv
rtl/gond_if.sv
rtl/gond_mem.sv
rtl/gond_ctrl.sv
rtl/gond_stencil.sv
rtl/grid_open_neighbour_degree.sv
tb/testbench.sv
